// ===== sv/tdd_pkg.sv =====
// Package for the timeout-to-deadline block: request, response and divider cell types,
// unit codes and the unit scale table. No dependencies.
package tdd_pkg;

  // Number of restoring-division cells, one per dividend bit
  localparam int unsigned NumCells = 64;

  // Reset value of the counter period register
  localparam logic [31:0] PeriodReset = 32'd69841279;

  // Unit codes of a request
  typedef enum logic [2:0] {
    UnitFemto = 3'd0,
    UnitPico  = 3'd1,
    UnitNano  = 3'd2,
    UnitMicro = 3'd3,
    UnitMilli = 3'd4
  } unit_e;

  // Request word
  typedef struct packed {
    logic [63:0] duration;
    logic [2:0]  time_unit;
    logic [63:0] counter_now;
  } req_t;

  // Response word
  typedef struct packed {
    logic [63:0] deadline;
    logic [63:0] tick_count;
    logic        scale_saturated;
    logic        raised_to_minimum;
  } rsp_t;

  // State held by one divider cell
  typedef struct packed {
    logic        valid;
    logic [31:0] rem;
    logic [63:0] work;
    logic [63:0] now;
    logic        sat;
    logic        raised;
  } cell_t;

  // Femtoseconds per unit; unknown codes scale to zero
  function automatic logic [39:0] unit_scale(input logic [2:0] code);
    logic [39:0] k;
    unique case (unit_e'(code))
      UnitFemto: k = 40'd1;
      UnitPico:  k = 40'd1000;
      UnitNano:  k = 40'd1000000;
      UnitMicro: k = 40'd1000000000;
      UnitMilli: k = 40'd1000000000000;
      default:   k = 40'd0;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/tdd_scale.sv =====
// Front end of the timeout-to-deadline block: unit scaling with saturation and the
// minimum-period clamp, feeding the first divider cell. Depends on tdd_pkg.
module tdd_scale import tdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  req_t        req_i,
  input  logic [31:0] period_i,
  output cell_t       cell_o
);

  logic [39:0]  k;
  logic [31:0]  dl, dh, kl;
  logic [7:0]   kh;

  logic         v1_q;
  logic [63:0]  pp0_q, pp1_q;
  logic [39:0]  pp2_q, pp3_q;
  logic [63:0]  now1_q;

  logic [104:0] prod;
  logic         v2_q;
  logic [63:0]  fs2_q, now2_q;
  logic         sat2_q;

  logic         raised;
  logic [63:0]  dividend;
  logic         v3_q;
  logic [31:0]  rem3_q;
  logic [63:0]  work3_q, now3_q;
  logic         sat3_q, raised3_q;

  // Split the duration into 32-bit halves and the scale into 32 and 8 bits for 32x32 products
  assign k  = unit_scale(req_i.time_unit);
  assign dl = req_i.duration[31:0];
  assign dh = req_i.duration[63:32];
  assign kl = k[31:0];
  assign kh = k[39:32];

  // Recombine the partial products into the full product
  assign prod = {1'b0, pp3_q, 64'd0}
              + {9'd0, pp1_q, 32'd0}
              + {33'd0, pp2_q, 32'd0}
              + {41'd0, pp0_q};

  // Raise a duration shorter than one period to exactly one period
  assign raised   = fs2_q < {32'd0, period_i};
  assign dividend = raised ? {32'd0, period_i} : fs2_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Hold partial products, the saturated sum and the clamped dividend
  always_ff @(posedge clk_i) begin
    pp0_q  <= dl * kl;
    pp1_q  <= dh * kl;
    pp2_q  <= dl * kh;
    pp3_q  <= dh * kh;
    now1_q <= req_i.counter_now;

    sat2_q <= |prod[104:64];
    fs2_q  <= (|prod[104:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
    now2_q <= now1_q;

    rem3_q    <= 32'd0;
    work3_q   <= dividend;
    now3_q    <= now2_q;
    sat3_q    <= sat2_q;
    raised3_q <= raised;
  end

  always_comb begin
    cell_o.valid  = v3_q;
    cell_o.rem    = rem3_q;
    cell_o.work   = work3_q;
    cell_o.now    = now3_q;
    cell_o.sat    = sat3_q;
    cell_o.raised = raised3_q;
  end

endmodule

// ===== sv/tdd_div_cell.sv =====
// One restoring-division cell: takes one dividend bit, produces one quotient bit and
// hands the partial remainder on to the next cell. Depends on tdd_pkg.
module tdd_div_cell import tdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] period_i,
  input  cell_t       cell_i,
  output cell_t       cell_o
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic        valid_q;
  logic [31:0] rem_q;
  logic [63:0] work_q;
  logic [63:0] now_q;
  logic        sat_q;
  logic        raised_q;

  // Bring in the next dividend bit and try to subtract the period
  assign trial = {cell_i.rem, cell_i.work[63]};
  assign diff  = trial - {1'b0, period_i};
  assign ge    = trial >= {1'b0, period_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  // Shift the quotient bit in and pass the side fields along
  always_ff @(posedge clk_i) begin
    rem_q    <= ge ? diff[31:0] : trial[31:0];
    work_q   <= {cell_i.work[62:0], ge};
    now_q    <= cell_i.now;
    sat_q    <= cell_i.sat;
    raised_q <= cell_i.raised;
  end

  always_comb begin
    cell_o.valid  = valid_q;
    cell_o.rem    = rem_q;
    cell_o.work   = work_q;
    cell_o.now    = now_q;
    cell_o.sat    = sat_q;
    cell_o.raised = raised_q;
  end

endmodule

// ===== sv/timer_deadline_from_duration.sv =====
// Top level of the timeout-to-deadline block: period register, front end, divider row
// and the deadline adder. Depends on tdd_pkg, tdd_scale and tdd_div_cell.

// A request is taken in every cycle (busy stays low), and its response shows on rsp_o
// with done_o high for one cycle, in request order. The pipeline has three front-end
// stages (partial products, product sum and saturation, period clamp), one stage per
// quotient bit in the 64-cell divider row, and one stage for the deadline add. The
// receiver cannot stall: a response must be taken in the cycle it is shown. Write the
// counter period only while no request is in flight.
module timer_deadline_from_duration import tdd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned LatCycles = 3 + NumCells + 1;

  logic [31:0] period_q;
  cell_t       chain [NumCells+1];
  logic        done_q;
  rsp_t        rsp_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Hold the counter period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      period_q <= cfg_data_i;
    end
  end

  tdd_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .req_i    (req_i),
    .period_i (period_q),
    .cell_o   (chain[0])
  );

  // Row of division cells, one quotient bit each
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    tdd_div_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .period_i (period_q),
      .cell_i   (chain[g]),
      .cell_o   (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[NumCells].valid;
    end
  end

  // Add the ticks to the sampled counter value
  always_ff @(posedge clk_i) begin
    rsp_q.deadline          <= chain[NumCells].now + chain[NumCells].work;
    rsp_q.tick_count        <= chain[NumCells].work;
    rsp_q.scale_saturated   <= chain[NumCells].sat;
    rsp_q.raised_to_minimum <= chain[NumCells].raised;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A saturated duration is never below one period
  a_sat_not_raised: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.scale_saturated && rsp_o.raised_to_minimum))
    else $error("saturated response also flagged as raised");

  // An unknown unit code never saturates, and its response arrives on time
  a_unknown_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.time_unit > UnitMilli))
    |-> ##LatCycles (done_o && !rsp_o.scale_saturated))
    else $error("unknown unit response missing or saturated");

  // A zero duration cannot saturate
  a_zero_duration: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.duration == 64'd0)
    |-> ##LatCycles (done_o && !rsp_o.scale_saturated))
    else $error("zero duration response missing or saturated");

endmodule

// ===== tb/tb_timer_deadline_from_duration.sv =====
// Testbench for timer_deadline_from_duration: directed and random timeout requests under
// several counter periods, each response checked against an in-bench deadline predictor.
// Depends on tdd_pkg and the timer_deadline_from_duration RTL.
module tb_timer_deadline_from_duration;
  import tdd_pkg::*;

  // Pipeline depth of the block plus a margin
  localparam int unsigned DrainCycles = 72;
  localparam int unsigned ReportLimit = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  // Pending requests, expected responses and the predictor's copy of the period
  req_t        request_queue[$];
  rsp_t        deadline_expect[$];
  logic [31:0] period_fs = PeriodReset;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned fail_count = 0;
  logic        sender_pauses = 1'b0;
  int          gap_left = 0;
  logic        next_start;
  req_t        next_req;

  timer_deadline_from_duration DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Femtoseconds per unit; unknown codes give zero
  function automatic logic [63:0] fs_per_unit(input logic [2:0] code);
    case (code)
      UnitFemto: return 64'd1;
      UnitPico:  return 64'd1000;
      UnitNano:  return 64'd1000000;
      UnitMicro: return 64'd1000000000;
      UnitMilli: return 64'd1000000000000;
      default:   return 64'd0;
    endcase
  endfunction

  // Scale, saturate, clamp to one period, divide and add to counter (period 0: all ones)
  function automatic rsp_t predict_deadline(input req_t r, input logic [31:0] period);
    logic [127:0] product;
    logic [63:0]  fs;
    rsp_t         e;
    e = '0;
    product = {64'd0, r.duration} * {64'd0, fs_per_unit(r.time_unit)};
    if (product[127:64] != '0) begin
      fs = '1;
      e.scale_saturated = 1'b1;
    end else begin
      fs = product[63:0];
    end
    if (period == '0) begin
      e.tick_count = '1;
    end else begin
      if (fs < {32'd0, period}) begin
        fs = {32'd0, period};
        e.raised_to_minimum = 1'b1;
      end
      e.tick_count = fs / {32'd0, period};
    end
    e.deadline = r.counter_now + e.tick_count;
    return e;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random request, weighted toward the saturation limit and the one-period floor
  function automatic req_t random_request(input logic [31:0] period);
    req_t        r;
    logic [63:0] k;
    if ($urandom_range(0, 7) == 0) r.counter_now = ~64'($urandom_range(0, 255));
    else r.counter_now = rand64();
    if ($urandom_range(0, 4) == 0) r.time_unit = 3'($urandom());
    else r.time_unit = 3'($urandom_range(UnitFemto, UnitMilli));
    k = fs_per_unit(r.time_unit);
    case ($urandom_range(0, 4))
      0: r.duration = rand64();
      1: r.duration = rand64() >> $urandom_range(0, 63);
      2: begin
        if (k != '0) r.duration = ('1 / k) + 64'($urandom_range(0, 2)) - 64'd1;
        else r.duration = rand64();
      end
      3: begin
        if (k != '0) r.duration = ({32'd0, period} + 64'($urandom_range(0, 2)) - 64'd1) / k;
        else r.duration = 64'($urandom_range(0, 3));
      end
      default: r.duration = 64'($urandom_range(0, 3));
    endcase
    return r;
  endfunction

  task automatic add_request(input logic [63:0] dur, input logic [2:0] code,
                             input logic [63:0] now);
    req_t r;
    r.duration = dur;
    r.time_unit = code;
    r.counter_now = now;
    request_queue.push_back(r);
    n_queued++;
  endtask

  task automatic add_random(input int unsigned count);
    repeat (count) begin
      request_queue.push_back(random_request(period_fs));
      n_queued++;
    end
  endtask

  // Hold until every queued word is accepted and every response has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (n_accepted != n_queued || deadline_expect.size() != 0);
  endtask

  task automatic write_period(input logic [31:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    period_fs = value;
  endtask

  task automatic report_fault(input string msg);
    if (fail_count < ReportLimit) $display("%s", msg);
    fail_count++;
  endtask

  // Drive request words; record the expected response at each accepting edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
      gap_left = 0;
    end else begin
      next_start = start;
      next_req = req_i;
      if (start && !busy) begin
        deadline_expect.push_back(predict_deadline(req_i, period_fs));
        n_accepted++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() != 0) begin
          if (sender_pauses && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 7);
          end else begin
            next_req = request_queue.pop_front();
            next_start = 1'b1;
          end
        end
      end
      start <= next_start;
      req_i <= next_req;
    end
  end

  // Compare each response word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (deadline_expect.size() == 0) begin
        report_fault($sformatf("unexpected response: deadline=%h ticks=%h sat=%b raised=%b",
                               rsp_o.deadline, rsp_o.tick_count, rsp_o.scale_saturated,
                               rsp_o.raised_to_minimum));
      end else begin
        rsp_t e;
        e = deadline_expect.pop_front();
        if (rsp_o.deadline !== e.deadline || rsp_o.tick_count !== e.tick_count ||
            rsp_o.scale_saturated !== e.scale_saturated ||
            rsp_o.raised_to_minimum !== e.raised_to_minimum) begin
          report_fault($sformatf(
            "response error: deadline exp %h got %h, ticks exp %h got %h, sat exp %b got %b, raised exp %b got %b",
            e.deadline, rsp_o.deadline, e.tick_count, rsp_o.tick_count,
            e.scale_saturated, rsp_o.scale_saturated,
            e.raised_to_minimum, rsp_o.raised_to_minimum));
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("timer_deadline_from_duration: mismatch");
    $finish;
  end

  // Run the phases: directed words at reset period, then random words per period
  initial begin
    int c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero duration in every known unit raises to one period
    for (c = UnitFemto; c <= UnitMilli; c++) add_request('0, 3'(c), rand64());
    // unknown codes scale to zero regardless of duration
    for (c = int'(UnitMilli) + 1; c < (1 << $bits(unit_e)); c++) begin
      add_request(rand64(), 3'(c), rand64());
    end
    // exactly at and just past the saturation limit of each scaled unit
    for (c = UnitPico; c <= UnitMilli; c++) begin
      add_request('1 / fs_per_unit(3'(c)), 3'(c), rand64());
      add_request(('1 / fs_per_unit(3'(c))) + 64'd1, 3'(c), rand64());
    end
    add_request('1, UnitFemto, '0);
    add_request({32'd0, PeriodReset} - 64'd1, UnitFemto, rand64());
    add_request({32'd0, PeriodReset}, UnitFemto, rand64());
    add_request({32'd0, PeriodReset} + 64'd1, UnitFemto, rand64());
    // deadline wraps past the top of the counter
    add_request(64'd1000, UnitMilli, '1);
    wait_drained();

    sender_pauses = 1'b1;
    write_period(32'd1);
    add_random(80);
    wait_drained();

    write_period('1);
    add_random(80);
    wait_drained();

    sender_pauses = 1'b0;
    write_period(32'($urandom_range(1, 32'hFFFF_FFFF)));
    add_random(80);
    wait_drained();

    sender_pauses = 1'b1;
    write_period(32'($urandom_range(1, 1000)));
    add_random(80);
    wait_drained();

    write_period(PeriodReset);
    add_random(80);
    wait_drained();

    write_period(32'($urandom_range(1000000, 1000000000)));
    add_random(80);
    wait_drained();

    // closing stretch runs back to back
    sender_pauses = 1'b0;
    write_period(32'($urandom_range(1, 32'hFFFF_FFFF)));
    add_random(70);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (deadline_expect.size() != 0) begin
      report_fault($sformatf("%0d responses never arrived", deadline_expect.size()));
    end
    if (fail_count == 0) begin
      $display("timer_deadline_from_duration: match");
    end else begin
      $display("timer_deadline_from_duration: mismatch");
    end
    $finish;
  end

endmodule
